[rtl/sha512_pkg.sv]
package sha512_pkg;

  localparam int WordW = 64;
  localparam int NumRounds = 80;
  localparam int WinDepth = 16;

  localparam logic [WordW-1:0] PadWord = 64'h8000000000000000;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t init_h(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [6:0] t);
    word_t r;
    case (t)
      7'd0: r = 64'h428a2f98d728ae22;  7'd1: r = 64'h7137449123ef65cd;
      7'd2: r = 64'hb5c0fbcfec4d3b2f;  7'd3: r = 64'he9b5dba58189dbbc;
      7'd4: r = 64'h3956c25bf348b538;  7'd5: r = 64'h59f111f1b605d019;
      7'd6: r = 64'h923f82a4af194f9b;  7'd7: r = 64'hab1c5ed5da6d8118;
      7'd8: r = 64'hd807aa98a3030242;  7'd9: r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec; default: r = 64'h6c44198c4a475817;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (WordW - n));
  endfunction

  // Round datapath request from the sequencer.
  typedef struct packed {
    logic       load;   // copy chaining value into working variables
    logic       round;  // perform one round
    logic       fold;   // add working variables into the chaining value
    logic       init;   // restore the initial hash value
    logic [6:0] t;
    word_t      w;
  } rnd_ctl_t;

endpackage

[rtl/sha512_round.sv]
module sha512_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha512_pkg::rnd_ctl_t ctl,
  input  logic [2:0]           rd_idx,
  output sha512_pkg::word_t    rd_word
);

  sha512_pkg::word_t h_r [8];
  sha512_pkg::word_t v_r [8];
  sha512_pkg::word_t t1, t2;

  always_comb begin
    t1 = v_r[7] + (sha512_pkg::rotr(v_r[4], 14) ^ sha512_pkg::rotr(v_r[4], 18)
         ^ sha512_pkg::rotr(v_r[4], 41)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + sha512_pkg::round_k(ctl.t) + ctl.w;
    t2 = (sha512_pkg::rotr(v_r[0], 28) ^ sha512_pkg::rotr(v_r[0], 34)
         ^ sha512_pkg::rotr(v_r[0], 39))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::init_h(3'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (ctl.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  assign rd_word = h_r[rd_idx];

endmodule

[rtl/sha512_hash_core_top.sv]
// SHA-512 hasher, one 64-bit message word per transfer; in_tready is high only while idle.
// A non-final word that does not complete a block is simply stored; a word that completes a
// block is followed by a schedule read (S_RD), 80 rounds (S_RND) and a fold (S_FOLD).
// A final word then gets one padding word per cycle and the same steps per further block,
// after which eight digest transfers follow, one per cycle while out_tready is high.
// Synchronous active-low reset restores the initial hash value and clears the counters.
module sha512_hash_core_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // data_word[63:0], byte_count[67:64], zero fill
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // digest_word[63:0], word_index[66:64], zero fill
  output logic        out_tlast   // last_digest
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // Window memory: one write port, four read ports for the schedule taps.
  sha512_pkg::word_t win_mem [sha512_pkg::WinDepth];
  sha512_pkg::word_t rd_a_r, rd_b_r, rd_c_r, rd_d_r;

  logic [2:0]  st_r, st_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [63:0] bytes_r, bytes_nxt;
  logic [6:0]  t_r, t_nxt;
  logic [1:0]  pad_r, pad_nxt;   // 0 filler zeros, 1 length high, 2 length low, 3 mark
  logic        fin_r, fin_nxt;   // padding pending after this block
  logic [2:0]  oi_r, oi_nxt;

  logic        we;
  logic [3:0]  wa;
  sha512_pkg::word_t wd, w_calc, sg0, sg1;
  sha512_pkg::rnd_ctl_t ctl;
  sha512_pkg::word_t dig;
  logic [3:0]  ra_a, ra_b, ra_c, ra_d;
  logic [3:0]  cnt;
  logic [63:0] keep, dw;
  logic [3:0]  bc;

  sha512_round u_round (.clk(clk), .rst_n(rst_n), .ctl(ctl), .rd_idx(oi_r), .rd_word(dig));

  assign dw = in_tdata[63:0];
  assign bc = in_tdata[67:64];
  assign cnt = (!in_tlast || bc > 4'd8) ? 4'd8 : bc;

  // Schedule: taps for round t+1 are read during round t.
  assign ra_d = 4'(t_nxt);
  assign ra_a = 4'(t_nxt - 7'd2);
  assign ra_b = 4'(t_nxt - 7'd15);
  assign ra_c = 4'(t_nxt - 7'd7);

  always_ff @(posedge clk) begin
    if (we) win_mem[wa] <= wd;
    rd_a_r <= win_mem[ra_a];
    rd_b_r <= win_mem[ra_b];
    rd_c_r <= win_mem[ra_c];
    rd_d_r <= win_mem[ra_d];
  end

  always_comb begin
    sg1 = sha512_pkg::rotr(rd_a_r, 19) ^ sha512_pkg::rotr(rd_a_r, 61) ^ (rd_a_r >> 6);
    sg0 = sha512_pkg::rotr(rd_b_r, 1) ^ sha512_pkg::rotr(rd_b_r, 8) ^ (rd_b_r >> 7);
    w_calc = (t_r < 7'd16) ? rd_d_r : sg1 + rd_c_r + sg0 + rd_d_r;
  end

  always_comb begin
    st_nxt = st_r; slot_nxt = slot_r; bytes_nxt = bytes_r; t_nxt = t_r;
    pad_nxt = pad_r; fin_nxt = fin_r; oi_nxt = oi_r;
    we = 1'b0; wa = slot_r; wd = '0;
    ctl = '0; ctl.t = t_r; ctl.w = w_calc;
    in_tready = 1'b0;
    keep = (cnt == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {cnt, 3'b000});
    case (st_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          bytes_nxt = bytes_r + 64'(cnt);
          we = 1'b1;
          wd = (cnt == 4'd8) ? dw : ((dw & keep) | (sha512_pkg::PadWord >> {cnt, 3'b000}));
          slot_nxt = slot_r + 4'd1;
          fin_nxt = in_tlast;
          pad_nxt = (in_tlast && cnt == 4'd8) ? 2'd3 :
                    ((in_tlast && slot_r == 4'd13) ? 2'd1 : 2'd0);
          if (slot_r == 4'd15) begin
            st_nxt = S_RD; t_nxt = 7'd0;
          end else if (in_tlast) begin
            st_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        we = 1'b1;
        slot_nxt = slot_r + 4'd1;
        case (pad_r)
          2'd3: begin
            wd = sha512_pkg::PadWord;
            pad_nxt = (slot_r == 4'd13) ? 2'd1 : 2'd0;
          end
          2'd1: begin wd = {61'd0, bytes_r[63:61]}; pad_nxt = 2'd2; end
          2'd2: begin wd = {bytes_r[60:0], 3'd0}; fin_nxt = 1'b0; end
          default: begin
            wd = '0;
            if (slot_r == 4'd13) pad_nxt = 2'd1;
          end
        endcase
        // The length goes in slots 14 and 15; a mark or zero in slot 15 forces a new block.
        if (slot_r == 4'd15) begin
          st_nxt = S_RD; t_nxt = 7'd0;
        end
      end
      S_RD: begin
        ctl.load = 1'b1;
        st_nxt = S_RND;
      end
      S_RND: begin
        ctl.round = 1'b1;
        if (t_r >= 7'd16) begin
          we = 1'b1; wa = t_r[3:0]; wd = w_calc;
        end
        t_nxt = t_r + 7'd1;
        if (t_r == 7'(sha512_pkg::NumRounds - 1)) st_nxt = S_FOLD;
      end
      S_FOLD: begin
        ctl.fold = 1'b1;
        slot_nxt = 4'd0;
        if (fin_r) st_nxt = S_PAD;
        else if (pad_r == 2'd2) begin st_nxt = S_OUT; oi_nxt = 3'd0; end
        else st_nxt = S_IDLE;
      end
      S_OUT: begin
        if (out_tready) begin
          oi_nxt = oi_r + 3'd1;
          if (oi_r == 3'd7) begin
            ctl.init = 1'b1; bytes_nxt = '0; pad_nxt = 2'd0; st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // In S_RD the first read uses t_nxt = 0, set on entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; slot_r <= '0; bytes_r <= '0; t_r <= '0;
      pad_r <= '0; fin_r <= 1'b0; oi_r <= '0;
    end else begin
      st_r <= st_nxt; slot_r <= slot_nxt; bytes_r <= bytes_nxt;
      t_r <= (st_r == S_RD) ? 7'd0 : t_nxt;
      pad_r <= pad_nxt; fin_r <= fin_nxt; oi_r <= oi_nxt;
    end
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {5'd0, oi_r, dig};
  assign out_tlast  = (oi_r == 3'd7);

endmodule
